[rtl/rlu_pkg.sv]
package rlu_pkg;

    localparam int PASSES   = 3;
    localparam int QUO_W    = 20;
    localparam int DIV_W    = 38;
    localparam int NORM_W   = 21;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTRE_X = 3'd2;
    localparam logic [2:0] CFG_CENTRE_Y = 3'd3;
    localparam logic [2:0] CFG_K1       = 3'd4;
    localparam logic [2:0] CFG_K2       = 3'd5;
    localparam logic [2:0] CFG_OFF_X    = 3'd6;
    localparam logic [2:0] CFG_OFF_Y    = 3'd7;

    localparam logic [QUO_W-1:0] NORM_MAX = {QUO_W{1'b1}};

    typedef logic [DIV_W-1:0] t_dnum;
    typedef logic [QUO_W-1:0] t_quo;

    typedef struct packed {
        logic                     valid;
        logic                     flag;
        logic                     skip;
        logic                     neg_x;
        logic                     neg_y;
        logic signed [NORM_W-1:0] x0;
        logic signed [NORM_W-1:0] y0;
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
    } t_tok;

    typedef struct packed {
        logic               valid;
        logic signed [17:0] cor_x;
        logic signed [17:0] cor_y;
        logic               flag;
    } t_res;

    // zero focal length acts as one
    function automatic logic [19:0] focal_eff(input logic [19:0] f);
        return (f == 20'd0) ? 20'd1 : f;
    endfunction

    // shift right with round half away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -$signed(r) : $signed(r);
    endfunction

    // signed normalized value from quotient magnitude, clamped on overflow
    function automatic logic signed [NORM_W-1:0] apply_quo(input t_quo q, input logic ovf,
                                                           input logic neg);
        logic [NORM_W-1:0] m;
        m = {1'b0, (ovf ? NORM_MAX : q)};
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

[rtl/rlu_divider.sv]
module rlu_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  rlu_pkg::t_tok  i_tok,
    input  rlu_pkg::t_dnum i_num [2],
    input  rlu_pkg::t_dnum i_den [2],
    output rlu_pkg::t_tok  o_tok,
    output rlu_pkg::t_quo  o_quo [2],
    output logic           o_ovf [2]
);

    localparam int QW = rlu_pkg::QUO_W;
    localparam int NW = rlu_pkg::DIV_W;
    localparam int WW = NW + QW;

    rlu_pkg::t_tok  r_tok [0:QW];
    rlu_pkg::t_dnum r_rem [0:1][0:QW];
    rlu_pkg::t_dnum r_dv  [0:1][0:QW];
    rlu_pkg::t_quo  r_q   [0:1][0:QW];
    logic           r_ovf [0:1][0:QW];

    rlu_pkg::t_dnum n_rem [0:1][0:QW-1];
    rlu_pkg::t_quo  n_q   [0:1][0:QW-1];
    logic [WW-1:0]  w_sh  [0:1][0:QW-1];
    logic           w_ovf0 [0:1];

    // quotient at or above 2^QW saturates, so test it up front
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ovf0[l] = {{QW{1'b0}}, i_num[l]} >= ({{QW{1'b0}}, i_den[l]} << QW);
            for (int k = 0; k < QW; k++) begin
                w_sh[l][k]  = {{QW{1'b0}}, r_dv[l][k]} << (QW - 1 - k);
                n_rem[l][k] = r_rem[l][k];
                n_q[l][k]   = r_q[l][k];
                if ({{QW{1'b0}}, r_rem[l][k]} >= w_sh[l][k]) begin
                    n_rem[l][k] = r_rem[l][k] - w_sh[l][k][NW-1:0];
                    n_q[l][k][QW-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) r_tok[k] <= '0;
        end else if (i_en) begin
            r_tok[0] <= i_tok;
            for (int k = 0; k < QW; k++) r_tok[k+1] <= r_tok[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= i_num[l];
                r_dv[l][0]  <= i_den[l];
                r_q[l][0]   <= '0;
                r_ovf[l][0] <= w_ovf0[l];
                for (int k = 0; k < QW; k++) begin
                    r_rem[l][k+1] <= n_rem[l][k];
                    r_dv[l][k+1]  <= r_dv[l][k];
                    r_q[l][k+1]   <= n_q[l][k];
                    r_ovf[l][k+1] <= r_ovf[l][k];
                end
            end
        end
    end

    assign o_tok    = r_tok[QW];
    assign o_quo[0] = r_q[0][QW];
    assign o_quo[1] = r_q[1][QW];
    assign o_ovf[0] = r_ovf[0][QW];
    assign o_ovf[1] = r_ovf[1][QW];

endmodule

[rtl/rlu_front.sv]
module rlu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [15:0]   i_pixel_x,
    input  logic [15:0]   i_pixel_y,
    input  logic [19:0]   i_focal_x,
    input  logic [19:0]   i_focal_y,
    input  logic [15:0]   i_centre_x,
    input  logic [15:0]   i_centre_y,
    input  logic [11:0]   i_off_x,
    input  logic [11:0]   i_off_y,
    output rlu_pkg::t_tok o_tok
);

    localparam int NW = rlu_pkg::DIV_W;

    rlu_pkg::t_tok  r_tok;
    rlu_pkg::t_dnum r_num [2];
    rlu_pkg::t_dnum r_den [2];
    rlu_pkg::t_tok  r_wb;

    rlu_pkg::t_tok  n_tok;
    rlu_pkg::t_tok  n_wb;
    rlu_pkg::t_dnum n_num [2];
    rlu_pkg::t_dnum n_den [2];
    logic signed [18:0] w_d [2];
    logic [16:0]        w_mag [2];
    logic [19:0]        w_f [2];

    rlu_pkg::t_tok  w_dtok;
    rlu_pkg::t_quo  w_quo [2];
    logic           w_ovf [2];

    always_comb begin
        w_f[0] = rlu_pkg::focal_eff(i_focal_x);
        w_f[1] = rlu_pkg::focal_eff(i_focal_y);
        w_d[0] = $signed({3'b0, i_pixel_x}) + $signed({3'b0, i_off_x, 4'b0})
               - $signed({3'b0, i_centre_x});
        w_d[1] = $signed({3'b0, i_pixel_y}) + $signed({3'b0, i_off_y, 4'b0})
               - $signed({3'b0, i_centre_y});
        for (int l = 0; l < 2; l++) begin
            w_mag[l] = (w_d[l] < 0) ? 17'(-w_d[l]) : 17'(w_d[l]);
            n_num[l] = {1'b0, w_mag[l], 20'b0} + NW'(w_f[l] >> 1);
            n_den[l] = NW'(w_f[l]);
        end
        n_tok       = '0;
        n_tok.valid = i_valid;
        n_tok.neg_x = w_d[0] < 0;
        n_tok.neg_y = w_d[1] < 0;

        n_wb      = w_dtok;
        n_wb.x0   = rlu_pkg::apply_quo(w_quo[0], w_ovf[0], w_dtok.neg_x);
        n_wb.x    = rlu_pkg::apply_quo(w_quo[0], w_ovf[0], w_dtok.neg_x);
        n_wb.y0   = rlu_pkg::apply_quo(w_quo[1], w_ovf[1], w_dtok.neg_y);
        n_wb.y    = rlu_pkg::apply_quo(w_quo[1], w_ovf[1], w_dtok.neg_y);
        n_wb.flag = w_ovf[0] | w_ovf[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_wb  <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
            r_wb  <= n_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    rlu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_tok   (r_tok),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_tok   (w_dtok),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf)
    );

    assign o_tok = r_wb;

endmodule

[rtl/rlu_pass.sv]
module rlu_pass (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [19:0] i_k1,
    input  logic signed [19:0] i_k2,
    input  rlu_pkg::t_tok      i_tok,
    output rlu_pkg::t_tok      o_tok
);

    localparam int NW = rlu_pkg::DIV_W;

    rlu_pkg::t_tok r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_wb;
    rlu_pkg::t_tok n_t7, n_wb;

    logic signed [41:0] r_sqx, r_sqy;
    logic [25:0]        r_r2;
    logic [51:0]        r_r2sq;
    logic signed [46:0] r_k1r2;
    logic [35:0]        r_r4;
    logic signed [30:0] r_a1, r_a1d;
    logic signed [56:0] r_k2r4;
    logic signed [41:0] r_den;
    rlu_pkg::t_dnum     r_num [2];
    rlu_pkg::t_dnum     r_dv  [2];

    logic [41:0]        w_rx, w_ry;
    logic [52:0]        w_r4;
    logic signed [63:0] w_a1, w_a2;
    logic               w_skip;
    logic [19:0]        w_mx, w_my;
    logic [NW-1:0]      w_half;

    rlu_pkg::t_tok      w_dtok;
    rlu_pkg::t_quo      w_quo [2];
    logic               w_ovf [2];

    always_comb begin
        w_rx   = (r_sqx[41:0] + 42'd32768) >> 16;
        w_ry   = (r_sqy[41:0] + 42'd32768) >> 16;
        w_r4   = ({1'b0, r_r2sq} + 53'd32768) >> 16;
        w_a1   = rlu_pkg::rnd_shr(64'(r_k1r2), 16);
        w_a2   = rlu_pkg::rnd_shr(64'(r_k2r4), 16);
        w_skip = r_den <= 0;
        w_mx   = (r_t6.x0 < 0) ? 20'(-r_t6.x0) : 20'(r_t6.x0);
        w_my   = (r_t6.y0 < 0) ? 20'(-r_t6.y0) : 20'(r_t6.y0);
        w_half = NW'(r_den >>> 1);

        n_t7       = r_t6;
        n_t7.skip  = w_skip;
        n_t7.neg_x = r_t6.x0 < 0;
        n_t7.neg_y = r_t6.y0 < 0;
        // non-positive denominator: keep the iterate, raise the flag
        n_wb = w_dtok;
        if (w_dtok.skip) begin
            n_wb.flag = 1'b1;
        end else begin
            n_wb.x    = rlu_pkg::apply_quo(w_quo[0], w_ovf[0], w_dtok.neg_x);
            n_wb.y    = rlu_pkg::apply_quo(w_quo[1], w_ovf[1], w_dtok.neg_y);
            n_wb.flag = w_dtok.flag | w_ovf[0] | w_ovf[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0; r_t2 <= '0; r_t3 <= '0; r_t4 <= '0;
            r_t5 <= '0; r_t6 <= '0; r_t7 <= '0; r_wb <= '0;
        end else if (i_en) begin
            r_t1 <= i_tok;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            r_t5 <= r_t4;
            r_t6 <= r_t5;
            r_t7 <= n_t7;
            r_wb <= n_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx  <= i_tok.x * i_tok.x;
            r_sqy  <= i_tok.y * i_tok.y;
            r_r2   <= w_rx[25:0] + w_ry[25:0];
            r_r2sq <= r_r2 * r_r2;
            r_k1r2 <= i_k1 * $signed({1'b0, r_r2});
            r_r4   <= w_r4[35:0];
            r_a1   <= w_a1[30:0];
            r_k2r4 <= i_k2 * $signed({1'b0, r_r4});
            r_a1d  <= r_a1;
            r_den  <= 42'sd65536 + 42'(r_a1d) + w_a2[41:0];
            r_num[0] <= {w_mx, 16'b0} + w_half;
            r_num[1] <= {w_my, 16'b0} + w_half;
            r_dv[0]  <= r_den[NW-1:0];
            r_dv[1]  <= r_den[NW-1:0];
        end
    end

    rlu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_tok   (r_t7),
        .i_num   (r_num),
        .i_den   (r_dv),
        .o_tok   (w_dtok),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf)
    );

    assign o_tok = r_wb;

endmodule

[rtl/rlu_back.sv]
module rlu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [19:0]   i_focal_x,
    input  logic [19:0]   i_focal_y,
    input  logic [15:0]   i_centre_x,
    input  logic [15:0]   i_centre_y,
    input  rlu_pkg::t_tok i_tok,
    output rlu_pkg::t_res o_res
);

    logic               r_valid, r_flag;
    logic signed [41:0] r_px, r_py;
    rlu_pkg::t_res      r_res;
    rlu_pkg::t_res      n_res;

    logic signed [63:0] w_rx, w_ry;
    logic signed [23:0] w_sx, w_sy;
    logic               w_fx, w_fy;
    logic signed [17:0] w_cx, w_cy;

    always_comb begin
        w_rx = rlu_pkg::rnd_shr(64'(r_px), 20);
        w_ry = rlu_pkg::rnd_shr(64'(r_py), 20);
        w_sx = w_rx[23:0] + $signed({8'b0, i_centre_x});
        w_sy = w_ry[23:0] + $signed({8'b0, i_centre_y});
        w_fx = (w_sx > 24'sd131071) || (w_sx < -24'sd131072);
        w_fy = (w_sy > 24'sd131071) || (w_sy < -24'sd131072);
        w_cx = (w_sx > 24'sd131071) ? 18'sd131071 :
               (w_sx < -24'sd131072) ? -18'sd131072 : w_sx[17:0];
        w_cy = (w_sy > 24'sd131071) ? 18'sd131071 :
               (w_sy < -24'sd131072) ? -18'sd131072 : w_sy[17:0];
        n_res.valid = r_valid;
        n_res.cor_x = w_cx;
        n_res.cor_y = w_cy;
        n_res.flag  = r_flag | w_fx | w_fy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_res   <= '0;
        end else if (i_en) begin
            r_valid <= i_tok.valid;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flag <= i_tok.flag;
            r_px   <= i_tok.x * $signed({1'b0, rlu_pkg::focal_eff(i_focal_x)});
            r_py   <= i_tok.y * $signed({1'b0, rlu_pkg::focal_eff(i_focal_y)});
        end
    end

    assign o_res = r_res;

endmodule

[rtl/radial_lens_undistort_top.sv]
// Radial lens undistortion: each request carries a Q12.4 point inside the capture
// window and yields one corrected Q13.4 point in full-sensor coordinates plus a range
// flag (clamp, saturation or a non-positive distortion denominator). The block is a
// fixed pipeline that takes one request every cycle while o_stall is low; its depth
// is set by the 20-stage restoring dividers, one in the normalization and one in
// each undistortion pass, and by the multiply stages of each pass. An output register
// plus a one-entry skid stage decouple the sides: i_stall holds the output register,
// a result arriving meanwhile lands in the skid entry, and the pipeline freezes
// while that entry is occupied. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only change while the pipeline is empty.
module radial_lens_undistort_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_pixel_x,
    input  logic [15:0]        i_pixel_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_corrected_x,
    output logic signed [17:0] o_corrected_y,
    output logic               o_range_flag,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [19:0]        i_cfg_data
);

    // configuration
    logic [19:0]        r_focal_x, r_focal_y;
    logic [15:0]        r_centre_x, r_centre_y;
    logic signed [19:0] r_k1, r_k2;
    logic [11:0]        r_off_x, r_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 20'd256;
            r_focal_y  <= 20'd256;
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_k1       <= '0;
            r_k2       <= '0;
            r_off_x    <= '0;
            r_off_y    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rlu_pkg::CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                rlu_pkg::CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                rlu_pkg::CFG_CENTRE_X: r_centre_x <= i_cfg_data[15:0];
                rlu_pkg::CFG_CENTRE_Y: r_centre_y <= i_cfg_data[15:0];
                rlu_pkg::CFG_K1:       r_k1       <= $signed(i_cfg_data);
                rlu_pkg::CFG_K2:       r_k2       <= $signed(i_cfg_data);
                rlu_pkg::CFG_OFF_X:    r_off_x    <= i_cfg_data[11:0];
                rlu_pkg::CFG_OFF_Y:    r_off_y    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless the skid entry is occupied
    logic w_en;
    logic r_skid_valid;
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    rlu_pkg::t_tok w_tok [0:rlu_pkg::PASSES];
    rlu_pkg::t_res w_res;

    rlu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_focal_x  (r_focal_x),
        .i_focal_y  (r_focal_y),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .i_off_x    (r_off_x),
        .i_off_y    (r_off_y),
        .o_tok      (w_tok[0])
    );

    // one fixed-point undistortion pass per instance
    for (genvar p = 0; p < rlu_pkg::PASSES; p++) begin : g_pass
        rlu_pass u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_k1    (r_k1),
            .i_k2    (r_k2),
            .i_tok   (w_tok[p]),
            .o_tok   (w_tok[p+1])
        );
    end

    rlu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_focal_x  (r_focal_x),
        .i_focal_y  (r_focal_y),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .i_tok      (w_tok[rlu_pkg::PASSES]),
        .o_res      (w_res)
    );

    // output register and skid entry
    logic               r_out_valid;
    logic signed [17:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic               r_out_flag, r_skid_flag;
    logic               w_take, w_arrive;

    assign w_take   = r_out_valid && !i_stall;
    assign w_arrive = w_en && w_res.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            // drain the skid entry first, else load the arriving request
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_arrive;
            end
        end else if (w_arrive) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_x    <= r_skid_x;
                r_out_y    <= r_skid_y;
                r_out_flag <= r_skid_flag;
            end else begin
                r_out_x    <= w_res.cor_x;
                r_out_y    <= w_res.cor_y;
                r_out_flag <= w_res.flag;
            end
        end else if (w_arrive) begin
            r_skid_x    <= w_res.cor_x;
            r_skid_y    <= w_res.cor_y;
            r_skid_flag <= w_res.flag;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_corrected_x = r_out_x;
    assign o_corrected_y = r_out_y;
    assign o_range_flag  = r_out_flag;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a request while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move to the output register");

    a_frozen_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && r_out_valid && i_stall) |=> (r_skid_valid && $stable(r_skid_x)))
        else $error("pipeline advanced while the skid entry was full");

endmodule
